### rtl/mpl_pkg.sv
`timescale 1ns / 1ps

package mpl_pkg;

  localparam int unsigned YearW    = 12;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned PhaseW   = 16;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned LedCount = 6;

  localparam int unsigned JdW    = 22;
  localparam int unsigned NW     = 24;
  localparam int unsigned FracW  = 32;
  localparam int unsigned ChunkW = 28;
  localparam int unsigned RecipW = 3 * ChunkW;
  localparam int unsigned RecipShift = 60;
  localparam int unsigned ProdW  = NW + ChunkW + 1;
  localparam int unsigned SumW   = FracW + RecipShift;

  localparam logic [13:0]     YearOffset  = 14'd4712;
  localparam logic [12:0]     Div100Mul   = 13'd5243;
  localparam int unsigned     Div100Shift = 19;
  localparam logic [6:0]      CentBias    = 7'd49;
  localparam logic [6:0]      CorrBias    = 7'd38;
  localparam logic [10:0]     DaysPer4Yr  = 11'd1461;
  localparam logic [JdW-1:0]  JdBias      = 22'd59;
  localparam logic [JdW-1:0]  GregSwitch  = 22'd2299160;
  localparam logic [24:0]     EpochTenths = 25'd24515501;

  localparam logic [127:0] SynodicE9 = 128'd29530588853;
  localparam logic [127:0] RecipNum  = 128'd100000000 << SumW;
  localparam logic [RecipW-1:0] RecipLo = RecipW'(RecipNum / SynodicE9);
  localparam logic [RecipW-1:0] RecipHi =
    RecipW'((RecipNum + SynodicE9 - 128'd1) / SynodicE9);

  localparam logic [FracW-1:0] FullLo    = 32'd2104533976;
  localparam logic [FracW-1:0] FullHi    = 32'd2190433320;
  localparam logic [FracW-1:0] HalfCycle = 32'h8000_0000;
  localparam logic [LevelW-1:0] LevelFull = 8'd255;
  localparam logic [LevelW-1:0] LevelOff  = 8'd0;

  typedef struct packed {
    logic [DayW-1:0]   day_of_month;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  typedef logic [LedCount-1:0][LevelW-1:0] levels_t;

  // Days from March to the start of the month, after the year is rotated to begin in March.
  function automatic logic [8:0] month_term(input logic [MonthW-1:0] month);
    logic [8:0] term;
    unique case (month)
      4'd0:    term = 9'd275;
      4'd1:    term = 9'd306;
      4'd2:    term = 9'd337;
      4'd3:    term = 9'd0;
      4'd4:    term = 9'd31;
      4'd5:    term = 9'd61;
      4'd6:    term = 9'd92;
      4'd7:    term = 9'd122;
      4'd8:    term = 9'd153;
      4'd9:    term = 9'd184;
      4'd10:   term = 9'd214;
      4'd11:   term = 9'd245;
      4'd12:   term = 9'd275;
      4'd13:   term = 9'd306;
      4'd14:   term = 9'd337;
      default: term = 9'd367;
    endcase
    return term;
  endfunction

endpackage

### rtl/mpl_julian.sv
`timescale 1ns / 1ps

module mpl_julian (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  mpl_pkg::date_t                date_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [mpl_pkg::NW-1:0] n_o
);
  import mpl_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v3_q;

  logic              adj;
  logic              ty_neg;
  logic [YearW-1:0]  yr_m;
  logic [24:0]       q_prod;
  logic [6:0]        cent;
  logic [8:0]        cent3;
  logic signed [5:0] corr_d;
  logic [13:0]       yp_d;

  always_comb begin
    adj    = date_i.month <= 4'd2;
    ty_neg = (date_i.year == '0) && adj;
    yr_m   = date_i.year - YearW'(adj);
    q_prod = 25'(yr_m) * 25'(Div100Mul);
    cent   = 7'(q_prod[24:Div100Shift]) + CentBias;
    cent3  = {1'b0, cent, 1'b0} + {2'b0, cent};
    corr_d = ty_neg ? -6'sd2 : $signed(6'(7'(cent3[8:2]) - CorrBias));
    yp_d   = {2'b0, date_i.year} + YearOffset - 14'(adj);
  end

  logic [13:0]       yp_q;
  logic [8:0]        mterm_q;
  logic [DayW-1:0]   day_q;
  logic signed [5:0] corr1_q;

  logic [24:0]       yr_prod;
  logic [JdW-1:0]    jraw_d;
  logic [JdW-1:0]    jraw_q;
  logic signed [5:0] corr2_q;

  always_comb begin
    yr_prod = 25'(yp_q) * 25'(DaysPer4Yr);
    jraw_d  = 22'(yr_prod[24:2]) + 22'(mterm_q) + 22'(day_q) + JdBias;
  end

  logic [JdW-1:0] jd;
  logic [25:0]    tenths;
  logic signed [NW-1:0] n_d;

  always_comb begin
    jd = jraw_q;
    if (jraw_q > GregSwitch) begin
      jd = jraw_q - {{(JdW - 6){corr2_q[5]}}, corr2_q};
    end
    tenths = {1'b0, jd, 3'b0} + {3'b0, jd, 1'b0};
    n_d    = $signed(NW'(tenths - 26'(EpochTenths)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      yp_q    <= yp_d;
      mterm_q <= month_term(date_i.month);
      day_q   <= date_i.day_of_month;
      corr1_q <= corr_d;
    end
    if (en2) begin
      jraw_q  <= jraw_d;
      corr2_q <= corr1_q;
    end
    if (en3) begin
      n_o <= n_d;
    end
  end

endmodule

### rtl/mpl_phase.sv
`timescale 1ns / 1ps

module mpl_phase (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [mpl_pkg::NW-1:0] n_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [mpl_pkg::FracW-1:0]     frac_o
);
  import mpl_pkg::*;

  logic v1_q, v2_q;
  logic en1, en2;

  assign en2 = !v2_q || ready_i;
  assign en1 = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v2_q;

  // The reciprocal is rounded down for a positive offset and up for a negative one, so the
  // product never lands above the exact value and its integer part is exact.
  logic [RecipW-1:0] recip;
  logic signed [ProdW-1:0] p0_d, p1_d, p2_d;
  logic signed [ProdW-1:0] p0_q, p1_q, p2_q;

  always_comb begin
    recip = n_i[NW-1] ? RecipHi : RecipLo;
    p0_d  = n_i * $signed({1'b0, recip[0 +: ChunkW]});
    p1_d  = n_i * $signed({1'b0, recip[ChunkW +: ChunkW]});
    p2_d  = n_i * $signed({1'b0, recip[2*ChunkW +: ChunkW]});
  end

  logic [SumW-1:0] sum;

  always_comb begin
    sum = {{(SumW - ProdW){p0_q[ProdW-1]}}, p0_q}
        + {{(SumW - ProdW - ChunkW){p1_q[ProdW-1]}}, p1_q, {ChunkW{1'b0}}}
        + {p2_q[SumW-2*ChunkW-1:0], {(2*ChunkW){1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
    if (en2) begin
      frac_o <= sum[SumW-1:RecipShift];
    end
  end

endmodule

### rtl/mpl_leds.sv
`timescale 1ns / 1ps

module mpl_leds (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [mpl_pkg::FracW-1:0]      frac_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [mpl_pkg::PhaseW-1:0]     phase_o,
  output mpl_pkg::levels_t               levels_o
);
  import mpl_pkg::*;

  logic v1_q, v2_q;
  logic en1, en2;

  assign en2 = !v2_q || ready_i;
  assign en1 = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v2_q;

  logic             full_d, wane_d;
  logic [FracW-1:0] span;
  logic [34:0]      slice_pos;

  always_comb begin
    full_d    = (frac_i >= FullLo) && (frac_i <= FullHi);
    wane_d    = frac_i > HalfCycle;
    span      = wane_d ? (32'd0 - frac_i) : frac_i;
    slice_pos = {span, 3'b0} + {1'b0, span, 2'b0};
  end

  logic              full_q, wane_q;
  logic [2:0]        slice_q;
  logic [FracW-1:0]  pos_q;
  logic [PhaseW-1:0] phase1_q;

  logic [39:0]       part_prod;
  logic [LevelW-1:0] part;
  logic [2:0]        lead;
  levels_t           levels_d;

  always_comb begin
    part_prod = {pos_q, 8'b0} - {8'b0, pos_q};
    part      = part_prod[39:32];
    lead      = 3'(LedCount - 1) - slice_q;
    for (int k = 0; k < LedCount; k++) begin
      if (full_q) begin
        levels_d[k] = LevelFull;
      end else if (!wane_q) begin
        levels_d[k] = (3'(k) < slice_q) ? LevelFull : ((3'(k) == slice_q) ? part : LevelOff);
      end else begin
        levels_d[k] = (3'(k) > lead) ? LevelFull : ((3'(k) == lead) ? part : LevelOff);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      full_q   <= full_d;
      wane_q   <= wane_d;
      slice_q  <= slice_pos[34:32];
      pos_q    <= slice_pos[31:0];
      phase1_q <= frac_i[FracW-1:FracW-PhaseW];
    end
    if (en2) begin
      phase_o  <= phase1_q;
      levels_o <= levels_d;
    end
  end

endmodule

### rtl/moon_phase_led_bar.sv
// Moon phase LED bar.
//
// A date request enters on the s_axis channel and one result leaves on the m_axis channel
// for every request, in order. The result carries the phase as a 16-bit fraction of the
// synodic month (0 new, 32768 full) and brightness levels for six LEDs.
//
// On the way from an accepted request to a valid result, three stages build the day number
// and the offset from the epoch, two form the phase through constant reciprocal partial
// products and their sum, and two derive the LED levels. Throughput is one request per
// cycle while m_axis_tready is high; every stage holds one request with its own valid bit.
//
// Reset clears every valid bit, so no result is pending afterwards. When the receiver
// stalls, the result holds on m_axis and the stages behind it keep filling empty slots;
// s_axis_tready falls only once all seven stages hold a request.
`timescale 1ns / 1ps

module moon_phase_led_bar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // year [11:0], month [15:12], day_of_month [20:16], zero [23:21]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // phase_fraction [15:0], led0_level [23:16] up to led5_level [63:56]
  output logic [63:0] m_axis_tdata
);
  import mpl_pkg::*;

  date_t date;

  assign date.year         = s_axis_tdata[11:0];
  assign date.month        = s_axis_tdata[15:12];
  assign date.day_of_month = s_axis_tdata[20:16];

  logic                 jul_valid, jul_ready;
  logic signed [NW-1:0] jul_n;
  logic                 ph_valid, ph_ready;
  logic [FracW-1:0]     ph_frac;
  logic [PhaseW-1:0]    phase;
  levels_t              levels;

  mpl_julian u_julian (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .date_i  (date),
    .valid_o (jul_valid),
    .ready_i (jul_ready),
    .n_o     (jul_n)
  );

  mpl_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (jul_valid),
    .ready_o (jul_ready),
    .n_i     (jul_n),
    .valid_o (ph_valid),
    .ready_i (ph_ready),
    .frac_o  (ph_frac)
  );

  mpl_leds u_leds (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (ph_valid),
    .ready_o  (ph_ready),
    .frac_i   (ph_frac),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .phase_o  (phase),
    .levels_o (levels)
  );

  assign m_axis_tdata = {levels, phase};

  // The input side can only be held off when a finished result is waiting.
  a_stall_needs_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  a_full_band : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (phase >= 16'd32113) && (phase <= 16'd33422)
    |-> (levels == {LedCount{LevelFull}}))
    else $error("full moon result without every LED at full level");

  a_waxing_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (phase < 16'd32112)
    |-> (levels[0] >= levels[1]) && (levels[1] >= levels[2]) && (levels[2] >= levels[3])
        && (levels[3] >= levels[4]) && (levels[4] >= levels[5]) && (levels[5] != LevelFull))
    else $error("waxing levels do not fill from the left");

  a_waning_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (phase >= 16'd33424)
    |-> (levels[0] <= levels[1]) && (levels[1] <= levels[2]) && (levels[2] <= levels[3])
        && (levels[3] <= levels[4]) && (levels[4] <= levels[5]) && (levels[0] != LevelFull))
    else $error("waning levels do not fill from the right");

endmodule
